@@ rtl/core/kds_pkg.sv @@
// Package for the kinetic drag scroll controller: payload types, constants, helpers.
`default_nettype none
package kds_pkg;

	localparam int unsigned REVERSAL_SLACK = 3;
	localparam int unsigned STEP_LIMIT     = 10;
	localparam int unsigned SPEED_SHIFT    = 4;  // speed is in 1/16 pixel
	localparam int unsigned SPEED_DECAY    = 7;

	typedef enum logic [0:0] {
		CFG_MAX_SCROLL  = 1'b0,
		CFG_CONTENT_TOP = 1'b1
	} kds_cfg_idx_t;

	localparam logic signed [1:0] DIR_NONE = 2'sd0;
	localparam logic signed [1:0] DIR_UP   = 2'sd1;
	localparam logic signed [1:0] DIR_DOWN = -2'sd1;

	typedef struct packed {
		logic        scroll_enabled;
		logic        pressed;
		logic        held;
		logic        released;
		logic [11:0] touch_y;
		logic [14:0] current_scroll;
	} kds_sample_t;

	typedef struct packed {
		logic               handled;
		logic               target_write;
		logic signed [15:0] target_pos;
		logic               full_redraw;
		logic               clear_history;
		logic               dragging;
	} kds_result_t;

	// Lower bound 0 first, then upper bound max_s.
	function automatic logic signed [15:0] clamp_target(input logic signed [16:0] t,
			input logic signed [15:0] max_s);
		logic signed [16:0] r;
		r = t;
		if (r < 17'sd0) begin
			r = 17'sd0;
		end
		if (r > $signed({max_s[15], max_s})) begin
			r = $signed({max_s[15], max_s});
		end
		return r[15:0];
	endfunction

	// Release velocity: sum/3 truncated toward zero, limited to +-10, times 16.
	function automatic logic signed [8:0] release_speed(input logic signed [14:0] sum);
		logic [14:0] mag;
		logic [3:0]  q;
		logic [8:0]  sp;
		mag = sum[14] ? 15'(-sum) : 15'(sum);
		q   = '0;
		if (mag >= 15'(3 * STEP_LIMIT + 3)) begin
			q = 4'(STEP_LIMIT);
		end else begin
			for (int k = 1; k <= int'(STEP_LIMIT); k++) begin
				if (mag >= 15'(3 * k)) begin
					q = 4'(k);
				end
			end
		end
		sp = {1'b0, q, 4'b0000};
		return sum[14] ? 9'(-$signed(sp)) : $signed(sp);
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/kds_stream_if.sv @@
// Valid/ready stream interface with a typed payload.
`default_nettype none
interface kds_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/kinetic_drag_scroll_controller.sv @@
// Kinetic drag scroll controller: touch samples in, scroll targets out.
//
// Usage:
//   sample : one touch sample per display frame (valid/ready, kds_sample_t).
//   result : exactly one result per sample, in order (valid/ready, kds_result_t).
//   cfg    : write port; cfg_we with cfg_index selects max_scroll or content_top.
//            Write only while no sample is in flight.
// Timing:
//   A sample is held in an input register, processed combinationally, and its
//   result lands in the output register.
//   One sample per cycle sustained while result is taken; the state update loop sets it.
// Stall:
//   When result is not taken, the output register holds; the input register
//   still takes one more sample, then sample.ready drops until result drains.
// Reset:
//   arst_n clears all drag state, both config registers and the pipeline.
`default_nettype none
module kinetic_drag_scroll_controller (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	kds_stream_if.sink                 sample,
	kds_stream_if.source               result,
	input  wire logic                  cfg_we,
	input  wire kds_pkg::kds_cfg_idx_t cfg_index,
	input  wire logic [15:0]           cfg_data
);
	import kds_pkg::*;

	// Config
	logic signed [15:0] max_scroll_q;
	logic [11:0]        content_top_q;

	// Drag state
	logic signed [13:0] origin_q, origin_d;
	logic [11:0]        last_y_q, last_y_d;
	logic signed [1:0]  dir_q, dir_d;
	logic [14:0]        anchor_q, anchor_d;
	logic [11:0]        turn_y_q, turn_y_d;
	logic signed [12:0] dlog_q [3];
	logic signed [12:0] dlog_d [3];
	logic signed [8:0]  speed_q, speed_d;
	logic               drag_q, drag_d;
	logic               region_q, region_d;

	// Pipeline
	logic        valid_s1, valid_s2;
	kds_sample_t data_s1;
	kds_result_t data_s2, res;
	logic        adv;

	// Step temporaries
	logic               done, region_eff, near_turn;
	logic [11:0]        y, eff;
	logic [14:0]        shown;
	logic signed [12:0] d, ty;
	logic signed [1:0]  dir;
	logic signed [16:0] tsum;
	logic signed [14:0] dsum;
	logic signed [8:0]  sp;
	logic [8:0]         mag, mag_dec;
	logic [4:0]         px;

	assign adv          = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || adv;
	assign result.valid = valid_s2;
	assign result.data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			data_s1 <= sample.data;
		end
		if (adv) begin
			data_s2 <= res;
		end
	end

	always_comb begin
		origin_d   = origin_q;
		last_y_d   = last_y_q;
		dir_d      = dir_q;
		anchor_d   = anchor_q;
		turn_y_d   = turn_y_q;
		dlog_d     = dlog_q;
		speed_d    = speed_q;
		drag_d     = drag_q;
		region_d   = region_q;
		res        = '0;
		y          = data_s1.touch_y;
		shown      = data_s1.current_scroll;
		done       = 1'b0;
		region_eff = region_q;
		eff        = y;
		d          = $signed({1'b0, y}) - $signed({1'b0, last_y_q});
		ty         = $signed({1'b0, y}) - $signed({1'b0, turn_y_q});
		near_turn  = (ty >= -13'sd3) && (ty <= 13'sd3);
		dir        = d[12] ? DIR_DOWN : DIR_UP;
		tsum       = '0;
		dsum       = 15'(dlog_q[0]) + 15'(dlog_q[1]) + 15'(dlog_q[2]);
		sp         = speed_q;
		mag        = '0;
		mag_dec    = '0;
		px         = '0;
		if (data_s1.scroll_enabled) begin
			if (data_s1.pressed) begin
				region_eff = y < content_top_q;
				region_d   = region_eff;
				if (region_eff) begin
					origin_d          = $signed({2'b00, y});
					anchor_d          = shown;
					last_y_d          = y;
					dir_d             = DIR_NONE;
					turn_y_d          = y;
					drag_d            = 1'b1;
					res.clear_history = 1'b1;
					res.full_redraw   = 1'b1;
					res.handled       = 1'b1;
					done              = 1'b1;
				end
			end
			if (!done && drag_q) begin
				res.handled = 1'b1;
				if (region_eff && data_s1.held) begin
					dlog_d[2] = dlog_q[1];
					dlog_d[1] = dlog_q[0];
					dlog_d[0] = d;
					if (d != 13'sd0) begin
						if (dir_q == DIR_NONE || dir_q == dir) begin
							dir_d    = dir;
							turn_y_d = y;
						end else if (near_turn) begin
							eff = last_y_q;
						end else begin
							dir_d    = dir;
							origin_d = d[12] ?
								$signed({2'b00, turn_y_q}) - 14'(REVERSAL_SLACK) :
								$signed({2'b00, turn_y_q}) + 14'(REVERSAL_SLACK);
							anchor_d        = shown;
							turn_y_d        = y;
							res.full_redraw = 1'b1;
						end
					end
					tsum = $signed({2'b00, anchor_d}) + 17'(origin_d)
						- $signed({5'b00000, eff});
					res.target_pos   = clamp_target(tsum, max_scroll_q);
					res.target_write = 1'b1;
					last_y_d         = y;
				end else begin
					if (region_eff && data_s1.released) begin
						sp = (dlog_q[0] == 13'sd0) ? 9'sd0 : release_speed(dsum);
					end
					if (sp != 9'sd0) begin
						mag     = sp[8] ? 9'(-sp) : 9'(sp);
						mag_dec = (mag >= 9'(SPEED_DECAY)) ? mag - 9'(SPEED_DECAY) : 9'd0;
						px      = mag[8:SPEED_SHIFT];
						tsum    = sp[8] ? $signed({2'b00, shown}) + $signed({12'd0, px}) :
							$signed({2'b00, shown}) - $signed({12'd0, px});
						res.target_pos   = clamp_target(tsum, max_scroll_q);
						res.target_write = 1'b1;
						sp = sp[8] ? 9'(-$signed(mag_dec)) : $signed(mag_dec);
						if ({1'b0, shown} == res.target_pos) begin
							sp = 9'sd0;
						end
					end
					speed_d = sp;
					if (sp == 9'sd0) begin
						drag_d = 1'b0;
					end
				end
			end
		end
		res.dragging = drag_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_scroll_q  <= '0;
			content_top_q <= '0;
			origin_q      <= '0;
			last_y_q      <= '0;
			dir_q         <= DIR_NONE;
			anchor_q      <= '0;
			turn_y_q      <= '0;
			dlog_q        <= '{default: '0};
			speed_q       <= '0;
			drag_q        <= 1'b0;
			region_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MAX_SCROLL:  max_scroll_q  <= $signed(cfg_data);
					CFG_CONTENT_TOP: content_top_q <= cfg_data[11:0];
					default: ;
				endcase
			end
			if (adv) begin
				origin_q <= origin_d;
				last_y_q <= last_y_d;
				dir_q    <= dir_d;
				anchor_q <= anchor_d;
				turn_y_q <= turn_y_d;
				dlog_q   <= dlog_d;
				speed_q  <= speed_d;
				drag_q   <= drag_d;
				region_q <= region_d;
			end
		end
	end

`ifndef ASSERT_OFF
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("input register did not advance into empty output register");

	a_speed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!drag_q |-> (speed_q == 9'sd0))
		else $error("nonzero velocity outside drag mode");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.clear_history) |->
		(result.data.full_redraw && result.data.dragging && result.data.handled))
		else $error("drag start without upload or drag mode");

	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		dir_q != 2'b10)
		else $error("invalid move direction");
`endif

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for kinetic_drag_scroll_controller: directed and random touch gestures.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kds_pkg::*;

	localparam int SLACK      = int'(REVERSAL_SLACK);
	localparam int STEP_MAX   = int'(STEP_LIMIT);
	localparam int SCALE      = 1 << SPEED_SHIFT;
	localparam int DECAY      = int'(SPEED_DECAY);
	localparam int STALL_MAX  = 2000;
	localparam int PRINT_MAX  = 40;

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	kds_cfg_idx_t  cfg_index;
	logic [15:0]   cfg_data;

	kds_stream_if #(.T(kds_sample_t)) sample_ch ();
	kds_stream_if #(.T(kds_result_t)) result_ch ();

	kinetic_drag_scroll_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// scroller model: configuration and drag state
	logic signed [15:0] lim_max  = '0;
	logic [11:0]        top_line = '0;
	int                 anchor_y    = 0;
	int                 prev_y      = 0;
	logic signed [1:0]  heading     = DIR_NONE;
	int                 base_scroll = 0;
	int                 pivot_y     = 0;
	int                 step_hist [3] = '{0, 0, 0};
	int                 vel         = 0;
	bit                 in_drag     = 1'b0;
	bit                 grabbed     = 1'b0;

	kds_result_t expected_q [$];
	kds_result_t last_res;
	int          n_items   = 0;
	int          n_results = 0;
	int          n_errors  = 0;
	int          tx_idle   = 0;
	int          rx_idle   = 0;
	int          disp      = 0;
	int          stall_cnt = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int mag_of(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int clip_target(input int t);
		if (t < 0) t = 0;
		if (t > int'(lim_max)) t = int'(lim_max);
		return t;
	endfunction

	function automatic kds_result_t predict_scroll(input kds_sample_t s);
		kds_result_t       r;
		int                y;
		int                shown;
		int                d;
		int                eff;
		int                t;
		int                mag;
		int                avg;
		logic signed [1:0] dir;
		bit                done;
		r     = '0;
		y     = int'(s.touch_y);
		shown = int'(s.current_scroll);
		done  = 1'b0;
		if (s.scroll_enabled) begin
			if (s.pressed) begin
				grabbed = (s.touch_y < top_line);
				if (grabbed) begin
					anchor_y        = y;
					base_scroll     = shown;
					prev_y          = y;
					heading         = DIR_NONE;
					pivot_y         = y;
					in_drag         = 1'b1;
					r.clear_history = 1'b1;
					r.full_redraw   = 1'b1;
					r.handled       = 1'b1;
					done            = 1'b1;
				end
			end
			if (!done && in_drag) begin
				r.handled = 1'b1;
				if (grabbed && s.held) begin
					eff         = y;
					d           = y - prev_y;
					step_hist[2] = step_hist[1];
					step_hist[1] = step_hist[0];
					step_hist[0] = d;
					if (d != 0) begin
						dir = (d < 0) ? DIR_DOWN : DIR_UP;
						if (heading == DIR_NONE || heading == dir) begin
							heading = dir;
							pivot_y = y;
						end else if (mag_of(y - pivot_y) <= SLACK) begin
							eff = prev_y;
						end else begin
							heading       = dir;
							anchor_y      = pivot_y + ((d < 0) ? -SLACK : SLACK);
							base_scroll   = shown;
							pivot_y       = y;
							r.full_redraw = 1'b1;
						end
					end
					r.target_pos   = 16'(clip_target(base_scroll + anchor_y - eff));
					r.target_write = 1'b1;
					prev_y         = y;
				end else begin
					if (grabbed && s.released) begin
						if (step_hist[0] == 0) begin
							vel = 0;
						end else begin
							avg = (step_hist[0] + step_hist[1] + step_hist[2]) / 3;
							if (avg > STEP_MAX) avg = STEP_MAX;
							else if (avg < -STEP_MAX) avg = -STEP_MAX;
							vel = avg * SCALE;
						end
					end
					if (vel != 0) begin
						mag            = mag_of(vel) - DECAY;
						t              = clip_target(shown - vel / SCALE);
						r.target_pos   = 16'(t);
						r.target_write = 1'b1;
						if (mag < 0) mag = 0;
						vel = (vel < 0) ? -mag : mag;
						if (shown == t) vel = 0;
					end
					if (vel == 0) in_drag = 1'b0;
				end
			end
		end
		r.dragging = in_drag;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (n_errors < PRINT_MAX)
			$display("[%0t] result %0d %s: got %0d, want %0d", $realtime, n_results, what, got,
				want);
		n_errors++;
	endtask

	task automatic send_sample(input kds_sample_t s);
		while ($urandom_range(99) < tx_idle) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data  <= s;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		last_res = predict_scroll(s);
		expected_q.push_back(last_res);
		if (s.scroll_enabled) n_items++;
		// display follows the target, now and then a frame late
		if (last_res.target_write && $urandom_range(9) != 0)
			disp = (last_res.target_pos < 0) ? 0 : int'(last_res.target_pos);
	endtask

	task automatic touch(input bit p, input bit h, input bit rl, input int y, input int sc);
		kds_sample_t s;
		s.scroll_enabled = 1'b1;
		s.pressed        = p;
		s.held           = h;
		s.released       = rl;
		s.touch_y        = 12'(y);
		s.current_scroll = 15'(sc);
		send_sample(s);
	endtask

	task automatic quiesce();
		sample_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input kds_cfg_idx_t idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_MAX_SCROLL:  lim_max  = data;
			CFG_CONTENT_TOP: top_line = data[11:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int max_s, input int top);
		quiesce();
		write_reg(CFG_MAX_SCROLL, 16'(max_s));
		write_reg(CFG_CONTENT_TOP, 16'(top));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// reset values: content_top 0, so no press can start a drag
	task automatic test_reset_defaults();
		kds_sample_t s;
		touch(1, 0, 0, 0, 0);
		touch(0, 1, 0, 5, 100);
		touch(0, 0, 1, 0, 0);
		s = '1;
		s.scroll_enabled = 1'b0;
		send_sample(s);
	endtask

	task automatic test_negative_limit();
		configure(-322, 4095);
		touch(1, 0, 0, 0, 0);
		touch(0, 1, 0, 4095, 32767);
		touch(0, 0, 1, 4095, 0);
		touch(0, 0, 0, 4095, 0);
	endtask

	task automatic test_reversal();
		configure(32767, 4095);
		touch(1, 0, 0, 2000, 1000);
		touch(0, 1, 0, 2010, 990);
		touch(0, 1, 0, 2020, 980);
		touch(0, 1, 0, 2018, 980);
		touch(0, 1, 0, 2015, 980);
		touch(0, 1, 0, 2015, 983);
		touch(0, 0, 1, 2015, 983);
		touch(0, 0, 0, 2015, 983);
		// upper clamp, then release sits on the limit
		touch(1, 0, 0, 4000, 32767);
		touch(0, 1, 0, 0, 32767);
		touch(0, 0, 1, 0, 32767);
	endtask

	task automatic test_inertia();
		touch(1, 0, 0, 100, 5000);
		touch(0, 1, 0, 130, 4970);
		touch(0, 1, 0, 160, 4940);
		touch(0, 1, 0, 190, 4910);
		touch(0, 0, 1, 190, 4910);
		touch(1, 0, 0, 4095, 4900);
		touch(0, 1, 0, 300, 4890);
		touch(1, 0, 0, 50, 4880);
		touch(0, 0, 0, 50, 4880);
		touch(0, 0, 0, 50, 0);
	endtask

	task automatic test_random_gestures(input int count);
		int          goal;
		int          y;
		int          dy;
		int          n;
		int          k;
		kds_sample_t s;
		goal = n_items + count;
		while (n_items < goal) begin
			if ($urandom_range(99) < 15 || top_line == 0) begin
				s = kds_sample_t'(31'($urandom));
				s.scroll_enabled = ($urandom_range(7) != 0);
				send_sample(s);
			end else begin
				y = $urandom_range(int'(top_line) - 1);
				touch(1, 0, 0, y, ($urandom_range(4) == 0) ? $urandom_range(32767) : disp);
				n = $urandom_range(12, 1);
				for (k = 0; k < n; k++) begin
					case ($urandom_range(9))
						0:       dy = int'($urandom_range(400)) - 200;
						1:       dy = 0;
						default: dy = int'($urandom_range(24)) - 12;
					endcase
					y = y + dy;
					if (y < 0) y = 0;
					if (y > 4095) y = 4095;
					touch(0, 1, 0, y, disp);
				end
				if ($urandom_range(9) != 0) touch(0, 0, 1, y, disp);
				n = $urandom_range(30);
				for (k = 0; k < n && last_res.dragging; k++) begin
					case ($urandom_range(19))
						0:       touch(1, 0, 0, $urandom_range(4095), disp);
						1:       touch(0, 1, 0, y, disp);
						default: touch(0, 0, 0, y, disp);
					endcase
				end
				if ($urandom_range(49) == 0) quiesce();
			end
		end
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		kds_result_t want;
		kds_result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result, handled", got.handled, 0);
			end else begin
				want = expected_q.pop_front();
				if (got.handled != want.handled)
					report_mismatch("handled", got.handled, want.handled);
				if (got.target_write != want.target_write)
					report_mismatch("target_write", got.target_write, want.target_write);
				if (got.target_pos !== want.target_pos)
					report_mismatch("target_pos", int'(got.target_pos), int'(want.target_pos));
				if (got.full_redraw != want.full_redraw)
					report_mismatch("full_redraw", got.full_redraw, want.full_redraw);
				if (got.clear_history != want.clear_history)
					report_mismatch("clear_history", got.clear_history, want.clear_history);
				if (got.dragging != want.dragging)
					report_mismatch("dragging", got.dragging, want.dragging);
			end
			n_results++;
		end
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else
			result_ch.ready <= ($urandom_range(99) >= rx_idle);
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_MAX) begin
			$display("kinetic_drag_scroll_controller: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_MAX_SCROLL;
		cfg_data        = '0;
		sample_ch.valid = 1'b0;
		sample_ch.data  = '0;
		tx_idle         = 16;
		rx_idle         = 74;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_negative_limit();
		test_reversal();
		test_inertia();

		configure(1200, 2048);
		test_random_gestures(620);

		tx_idle = 74;
		rx_idle = 16;
		configure(32767, 4095);
		test_random_gestures(620);

		tx_idle = 0;
		rx_idle = 0;
		configure(int'($urandom_range(33089)) - 322, $urandom_range(4095, 1));
		test_random_gestures(610);

		quiesce();
		repeat (8) @(posedge clk);
		if (expected_q.size() != 0)
			report_mismatch("results missing", 0, expected_q.size());
		if (n_errors == 0)
			$display("kinetic_drag_scroll_controller: match");
		else
			$display("kinetic_drag_scroll_controller: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/kds_pkg.sv
rtl/core/kds_stream_if.sv
rtl/core/kinetic_drag_scroll_controller.sv
tb/tb.sv
